>>> rtl/core/cau_pkg.sv
// Package for the complex arithmetic unit: widths, operation codes,
// pipeline payload structs and the 32-bit clamp function.
// No dependencies; every other file of the unit uses it.
package cau_pkg;

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 64;
  localparam int SUM_W    = PROD_W + 1;
  localparam int Q_W      = 33;
  localparam int REM_W    = PROD_W + Q_W;
  localparam int N_CELLS  = Q_W + 1;
  localparam int SQ_STEPS = 32;
  localparam int FRAC_DEF = 16;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_MAG = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } clamp_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [DATA_W-1:0]        add_re;
    logic [DATA_W-1:0]        add_im;
    logic                     add_sat;
    logic signed [PROD_W-1:0] ac;
    logic signed [PROD_W-1:0] bd;
    logic signed [PROD_W-1:0] bc;
    logic signed [PROD_W-1:0] ad;
    logic signed [PROD_W-1:0] cc;
    logic signed [PROD_W-1:0] dd;
  } mul_t;

  typedef struct packed {
    logic [2:0]              mode;
    logic [DATA_W-1:0]       add_re;
    logic [DATA_W-1:0]       add_im;
    logic                    add_sat;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic [PROD_W-1:0]       den;
  } sum_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [DATA_W-1:0] add_re;
    logic [DATA_W-1:0] add_im;
    logic              add_sat;
    logic              neg_re;
    logic              neg_im;
    logic [PROD_W-1:0] mag_re;
    logic [PROD_W-1:0] mag_im;
    logic [PROD_W-1:0] den;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [Q_W-1:0]    q_re;
    logic [Q_W-1:0]    q_im;
    logic              ovf_re;
    logic              ovf_im;
    logic [PROD_W-1:0] sq_rem;
    logic [PROD_W-1:0] sq_res;
  } pl_t;

  // Clamp a sign and magnitude to a signed 32-bit pattern.
  function automatic clamp_t clamp32(input logic neg, input logic [SUM_W-1:0] mag);
    clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > SUM_W'(33'h0_8000_0000)) begin
        r.val = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = DATA_W'(SUM_W'(0) - mag);
      end
    end else begin
      if (mag > SUM_W'(33'h0_7FFF_FFFF)) begin
        r.val = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.val = mag[DATA_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/cau_in_if.sv
// Input channel of the complex arithmetic unit: valid, ready and the
// operand beat. Depends on cau_pkg for widths.
interface cau_in_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       mode;
  logic signed [cau_pkg::DATA_W-1:0] left_re;
  logic signed [cau_pkg::DATA_W-1:0] left_im;
  logic signed [cau_pkg::DATA_W-1:0] right_re;
  logic signed [cau_pkg::DATA_W-1:0] right_im;

  modport source (output valid, mode, left_re, left_im, right_re, right_im, input ready);
  modport sink (input valid, mode, left_re, left_im, right_re, right_im, output ready);
endinterface

>>> rtl/core/cau_out_if.sv
// Result channel of the complex arithmetic unit: valid, ready and the
// result beat with its flags. Depends on cau_pkg for widths.
interface cau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cau_pkg::DATA_W-1:0] res_re;
  logic signed [cau_pkg::DATA_W-1:0] res_im;
  logic                             div_by_zero;
  logic                             saturated;

  modport source (output valid, res_re, res_im, div_by_zero, saturated, input ready);
  modport sink (input valid, res_re, res_im, div_by_zero, saturated, output ready);
endinterface

>>> rtl/core/cau_mul.sv
// Entry stage: registers the four cross products, the two squares of the right
// operand's parts, and the clamped sum or difference. Depends on cau_pkg, cau_in_if.
module cau_mul (
  input  logic           clk,
  input  logic           rst_n,
  cau_in_if.sink         in_ch,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cau_pkg::mul_t  dn_data
);

  logic                             valid_r;
  cau_pkg::mul_t                    data_r;
  cau_pkg::mul_t                    data_nxt;
  logic signed [cau_pkg::DATA_W:0]  s_re;
  logic signed [cau_pkg::DATA_W:0]  s_im;
  logic                             sat_re;
  logic                             sat_im;

  assign in_ch.ready = !valid_r || dn_ready;
  assign dn_valid    = valid_r;
  assign dn_data     = data_r;

  always_comb begin
    if (in_ch.mode == cau_pkg::MODE_ADD) begin
      s_re = {in_ch.left_re[31], in_ch.left_re} + {in_ch.right_re[31], in_ch.right_re};
      s_im = {in_ch.left_im[31], in_ch.left_im} + {in_ch.right_im[31], in_ch.right_im};
    end else begin
      s_re = {in_ch.left_re[31], in_ch.left_re} - {in_ch.right_re[31], in_ch.right_re};
      s_im = {in_ch.left_im[31], in_ch.left_im} - {in_ch.right_im[31], in_ch.right_im};
    end
    sat_re = s_re[32] != s_re[31];
    sat_im = s_im[32] != s_im[31];

    data_nxt.mode    = in_ch.mode;
    data_nxt.add_re  = sat_re ? (s_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s_re[31:0];
    data_nxt.add_im  = sat_im ? (s_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s_im[31:0];
    data_nxt.add_sat = sat_re || sat_im;
    data_nxt.ac      = $signed(in_ch.left_re) * $signed(in_ch.right_re);
    data_nxt.bd      = $signed(in_ch.left_im) * $signed(in_ch.right_im);
    data_nxt.bc      = $signed(in_ch.left_im) * $signed(in_ch.right_re);
    data_nxt.ad      = $signed(in_ch.left_re) * $signed(in_ch.right_im);
    data_nxt.cc      = $signed(in_ch.right_re) * $signed(in_ch.right_re);
    data_nxt.dd      = $signed(in_ch.right_im) * $signed(in_ch.right_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/core/cau_prep.sv
// Two stages that form the real and imaginary numerators and |right|^2,
// then split the numerators into sign and magnitude. Depends on cau_pkg.
module cau_prep #(
  parameter int FRAC_BITS = cau_pkg::FRAC_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  cau_pkg::mul_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output cau_pkg::pl_t  dn_data
);

  logic          a_valid_r;
  logic          a_ready;
  cau_pkg::sum_t a_r;
  cau_pkg::sum_t a_nxt;
  logic          b_valid_r;
  cau_pkg::pl_t  b_r;
  cau_pkg::pl_t  b_nxt;

  assign up_ready = !a_valid_r || a_ready;
  assign a_ready  = !b_valid_r || dn_ready;
  assign dn_valid = b_valid_r;
  assign dn_data  = b_r;

  // Multiply needs ac - bd and bc + ad; divide needs the conjugate form.
  always_comb begin
    a_nxt.mode    = up_data.mode;
    a_nxt.add_re  = up_data.add_re;
    a_nxt.add_im  = up_data.add_im;
    a_nxt.add_sat = up_data.add_sat;
    if (up_data.mode == cau_pkg::MODE_MUL) begin
      a_nxt.sum_re = {up_data.ac[63], up_data.ac} - {up_data.bd[63], up_data.bd};
      a_nxt.sum_im = {up_data.bc[63], up_data.bc} + {up_data.ad[63], up_data.ad};
    end else begin
      a_nxt.sum_re = {up_data.ac[63], up_data.ac} + {up_data.bd[63], up_data.bd};
      a_nxt.sum_im = {up_data.bc[63], up_data.bc} - {up_data.ad[63], up_data.ad};
    end
    a_nxt.den = up_data.cc + up_data.dd;
  end

  always_comb begin
    b_nxt         = '0;
    b_nxt.mode    = a_r.mode;
    b_nxt.add_re  = a_r.add_re;
    b_nxt.add_im  = a_r.add_im;
    b_nxt.add_sat = a_r.add_sat;
    b_nxt.neg_re  = a_r.sum_re[cau_pkg::SUM_W-1];
    b_nxt.neg_im  = a_r.sum_im[cau_pkg::SUM_W-1];
    b_nxt.mag_re  = b_nxt.neg_re ? cau_pkg::PROD_W'(-a_r.sum_re)
                                 : a_r.sum_re[cau_pkg::PROD_W-1:0];
    b_nxt.mag_im  = b_nxt.neg_im ? cau_pkg::PROD_W'(-a_r.sum_im)
                                 : a_r.sum_im[cau_pkg::PROD_W-1:0];
    b_nxt.den     = a_r.den;
    b_nxt.rem_re  = cau_pkg::REM_W'(b_nxt.mag_re) << FRAC_BITS;
    b_nxt.rem_im  = cau_pkg::REM_W'(b_nxt.mag_im) << FRAC_BITS;
    b_nxt.sq_rem  = a_r.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid_r <= up_valid;
      end
      if (a_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      a_r <= a_nxt;
    end
    if (a_valid_r && a_ready) begin
      b_r <= b_nxt;
    end
  end

endmodule

>>> rtl/core/cau_cell.sv
// One divide and root chain cell: restoring quotient bit per numerator
// lane (not in cell 0), root step in cells 0-31. Depends on cau_pkg.
module cau_cell #(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  cau_pkg::pl_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output cau_pkg::pl_t dn_data
);

  // Cell 0's divide lanes only check for a quotient of 2^33 or more.
  localparam int P  = cau_pkg::Q_W - STEP;
  localparam int SB = (STEP < cau_pkg::SQ_STEPS) ? 62 - 2 * STEP : 0;
  localparam logic [cau_pkg::PROD_W-1:0] SQ_BIT = cau_pkg::PROD_W'(1) << SB;

  logic                         valid_r;
  cau_pkg::pl_t                 data_r;
  cau_pkg::pl_t                 data_nxt;
  logic [cau_pkg::REM_W-1:0]    dsh;
  logic                         ge_re;
  logic                         ge_im;
  logic [cau_pkg::PROD_W-1:0]   sq_try;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt = up_data;
    dsh      = cau_pkg::REM_W'(up_data.den) << P;
    ge_re    = up_data.rem_re >= dsh;
    ge_im    = up_data.rem_im >= dsh;
    sq_try   = up_data.sq_res + SQ_BIT;
    if (STEP == 0) begin
      data_nxt.ovf_re = ge_re;
      data_nxt.ovf_im = ge_im;
    end else begin
      if (ge_re && !up_data.ovf_re) begin
        data_nxt.rem_re = up_data.rem_re - dsh;
        data_nxt.q_re   = up_data.q_re | (cau_pkg::Q_W'(1) << P);
      end
      if (ge_im && !up_data.ovf_im) begin
        data_nxt.rem_im = up_data.rem_im - dsh;
        data_nxt.q_im   = up_data.q_im | (cau_pkg::Q_W'(1) << P);
      end
    end
    if (STEP < cau_pkg::SQ_STEPS) begin
      if (up_data.sq_rem >= sq_try) begin
        data_nxt.sq_rem = up_data.sq_rem - sq_try;
        data_nxt.sq_res = (up_data.sq_res >> 1) + SQ_BIT;
      end else begin
        data_nxt.sq_res = up_data.sq_res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/core/cau_out.sv
// Result stage: rounds, clamps and selects by operation into the output
// register. Depends on cau_pkg and cau_out_if.
module cau_out #(
  parameter int FRAC_BITS = cau_pkg::FRAC_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  cau_pkg::pl_t up_data,
  cau_out_if.source    out_ch
);

  localparam logic [cau_pkg::SUM_W-1:0] HALF =
    cau_pkg::SUM_W'((cau_pkg::SUM_W'(1) << FRAC_BITS) >> 1);
  localparam logic [cau_pkg::SUM_W-1:0] OVF_MAG = cau_pkg::SUM_W'(1) << cau_pkg::Q_W;

  logic                        valid_r;
  logic [cau_pkg::DATA_W-1:0]  re_r;
  logic [cau_pkg::DATA_W-1:0]  im_r;
  logic                        dz_r;
  logic                        sat_r;
  logic [cau_pkg::DATA_W-1:0]  re_nxt;
  logic [cau_pkg::DATA_W-1:0]  im_nxt;
  logic                        dz_nxt;
  logic                        sat_nxt;
  cau_pkg::clamp_t             c_re;
  cau_pkg::clamp_t             c_im;
  logic [cau_pkg::SUM_W-1:0]   root;

  assign up_ready          = !valid_r || out_ch.ready;
  assign out_ch.valid       = valid_r;
  assign out_ch.res_re      = re_r;
  assign out_ch.res_im      = im_r;
  assign out_ch.div_by_zero = dz_r;
  assign out_ch.saturated   = sat_r;

  always_comb begin
    re_nxt  = '0;
    im_nxt  = '0;
    dz_nxt  = 1'b0;
    sat_nxt = 1'b0;
    c_re    = '0;
    c_im    = '0;
    root    = {1'b0, up_data.sq_res} +
              cau_pkg::SUM_W'(up_data.sq_rem > up_data.sq_res);
    case (up_data.mode)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        re_nxt  = up_data.add_re;
        im_nxt  = up_data.add_im;
        sat_nxt = up_data.add_sat;
      end
      cau_pkg::MODE_MUL: begin
        // Round to nearest with ties away from zero on the magnitude.
        c_re    = cau_pkg::clamp32(up_data.neg_re, ({1'b0, up_data.mag_re} + HALF) >> FRAC_BITS);
        c_im    = cau_pkg::clamp32(up_data.neg_im, ({1'b0, up_data.mag_im} + HALF) >> FRAC_BITS);
        re_nxt  = c_re.val;
        im_nxt  = c_im.val;
        sat_nxt = c_re.sat || c_im.sat;
      end
      cau_pkg::MODE_DIV: begin
        if (up_data.den == '0) begin
          dz_nxt = 1'b1;
        end else begin
          c_re    = cau_pkg::clamp32(up_data.neg_re,
                      up_data.ovf_re ? OVF_MAG : cau_pkg::SUM_W'(up_data.q_re));
          c_im    = cau_pkg::clamp32(up_data.neg_im,
                      up_data.ovf_im ? OVF_MAG : cau_pkg::SUM_W'(up_data.q_im));
          re_nxt  = c_re.val;
          im_nxt  = c_im.val;
          sat_nxt = c_re.sat || c_im.sat;
        end
      end
      cau_pkg::MODE_MAG: begin
        c_re    = cau_pkg::clamp32(1'b0, root);
        re_nxt  = c_re.val;
        sat_nxt = c_re.sat;
      end
      default: begin
        re_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      dz_r  <= dz_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

>>> rtl/core/complex_arithmetic_unit_top.sv
// Complex arithmetic unit, Q(31-FRAC_BITS).FRAC_BITS: add, subtract, multiply, divide, magnitude.
// Pipeline: entry stage, two numerator stages, 34 divide and root cells and the
// output register.
// Throughput: one beat per cycle while out_ch.ready is high; every stage advances on its
// own when its successor has room, so bubbles close up under back-pressure.
// Reset: synchronous active-low rst_n clears all stage valid bits.
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS = cau_pkg::FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cau_in_if.sink     in_ch,
  cau_out_if.source  out_ch
);

  logic          m_valid;
  logic          m_ready;
  cau_pkg::mul_t m_data;
  logic          c_valid [cau_pkg::N_CELLS+1];
  logic          c_ready [cau_pkg::N_CELLS+1];
  cau_pkg::pl_t  c_data  [cau_pkg::N_CELLS+1];

  cau_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (m_valid),
    .dn_ready (m_ready),
    .dn_data  (m_data)
  );

  cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (m_valid),
    .up_ready (m_ready),
    .up_data  (m_data),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_data  (c_data[0])
  );

  for (genvar g = 0; g < cau_pkg::N_CELLS; g++) begin : g_cell
    cau_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[g]),
      .up_ready (c_ready[g]),
      .up_data  (c_data[g]),
      .dn_valid (c_valid[g+1]),
      .dn_ready (c_ready[g+1]),
      .dn_data  (c_data[g+1])
    );
  end

  cau_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid[cau_pkg::N_CELLS]),
    .up_ready (c_ready[cau_pkg::N_CELLS]),
    .up_data  (c_data[cau_pkg::N_CELLS]),
    .out_ch   (out_ch)
  );

`ifndef ASSERT_OFF
  // Input stalls only when every stage, the output register included, is full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with a bubble in the pipeline");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("ready did not propagate to the input");

  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.div_by_zero |->
      out_ch.res_re == '0 && out_ch.res_im == '0 && !out_ch.saturated)
    else $error("divide by zero beat carries a nonzero result");

  a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    !c_valid[0] |=> !c_valid[1] || $stable(c_data[1]) || !$past(c_ready[0]))
    else $error("first cell loaded without an upstream beat");
`endif

endmodule

>>> tb/tb_complex_arithmetic_unit_top.sv
// Testbench for complex_arithmetic_unit_top: drives operand beats with random idling,
// predicts each result in a scoreboard class and checks the result beats in order.
// Depends on cau_pkg, cau_in_if, cau_out_if and the unit's RTL.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_top;

  localparam int FRAC = cau_pkg::FRAC_DEF;
  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
  localparam int N_RANDOM = 1130;

  typedef struct {
    logic [2:0]        mode;
    logic signed [31:0] a, b, c, d;
  } operands_t;

  typedef struct {
    logic [31:0] re, im;
    logic        dz, sat;
  } cplx_result_t;

  class alu_scoreboard;
    cplx_result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Clamp a sign and magnitude into the signed 32-bit range.
    static function logic [31:0] clamp_part(input bit neg, input logic [127:0] mag,
                                            inout bit sat);
      if (neg) begin
        if (mag > 128'h8000_0000) begin
          sat = 1'b1;
          return 32'h8000_0000;
        end
        return 32'(128'd0 - mag);
      end
      if (mag > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    endfunction

    static function logic [63:0] sqrt_round(input logic [63:0] x);
      logic [63:0] rem, res, b;
      rem = x;
      res = 0;
      b = 64'd1 << 62;
      while (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      if (rem > res) res = res + 1;
      return res;
    endfunction

    static function logic [127:0] mag_of(input logic signed [127:0] v);
      return v < 0 ? -v : v;
    endfunction

    static function cplx_result_t compute_cplx(input operands_t op);
      cplx_result_t r;
      logic signed [127:0] a, b, c, d, sr, si;
      logic [127:0] den;
      bit sat;
      a = op.a; b = op.b; c = op.c; d = op.d;
      sat = 0;
      r.re = 0; r.im = 0; r.dz = 0;
      case (op.mode)
        cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
          sr = (op.mode == cau_pkg::MODE_ADD) ? a + c : a - c;
          si = (op.mode == cau_pkg::MODE_ADD) ? b + d : b - d;
          r.re = clamp_part(sr < 0, mag_of(sr), sat);
          r.im = clamp_part(si < 0, mag_of(si), sat);
        end
        cau_pkg::MODE_MUL: begin
          // Round to nearest on the magnitude, so ties go away from zero.
          sr = a * c - b * d;
          si = b * c + a * d;
          r.re = clamp_part(sr < 0, (mag_of(sr) + (128'd1 << (FRAC - 1))) >> FRAC, sat);
          r.im = clamp_part(si < 0, (mag_of(si) + (128'd1 << (FRAC - 1))) >> FRAC, sat);
        end
        cau_pkg::MODE_DIV: begin
          den = c * c + d * d;
          if (den == 0) begin
            r.dz = 1;
          end else begin
            sr = a * c + b * d;
            si = b * c - a * d;
            r.re = clamp_part(sr < 0, (mag_of(sr) << FRAC) / den, sat);
            r.im = clamp_part(si < 0, (mag_of(si) << FRAC) / den, sat);
          end
        end
        cau_pkg::MODE_MAG: begin
          den = c * c + d * d;
          r.re = clamp_part(1'b0, {64'd0, sqrt_round(den[63:0])}, sat);
        end
        default: ;
      endcase
      r.sat = sat;
      return r;
    endfunction

    function void note_operands(input operands_t op);
      pending.push_back(compute_cplx(op));
    endfunction

    function void check_result(input cplx_result_t got);
      cplx_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat re=%h im=%h", $time, got.re, got.im);
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re || got.im !== want.im || got.dz !== want.dz ||
          got.sat !== want.sat) begin
        errors++;
        $display("%0t: mismatch expected re=%h im=%h dz=%b sat=%b, %s re=%h im=%h dz=%b sat=%b",
                 $time, want.re, want.im, want.dz, want.sat, "actual",
                 got.re, got.im, got.dz, got.sat);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  bit quiet = 0;
  alu_scoreboard sb = new();

  cau_in_if  in_ch();
  cau_out_if out_ch();

  complex_arithmetic_unit_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.mode = cau_pkg::MODE_ADD;
    in_ch.left_re = 0;
    in_ch.left_im = 0;
    in_ch.right_re = 0;
    in_ch.right_im = 0;
  end

  // Result side: ready drops in short random bursts until the quiet tail.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cplx_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.re = out_ch.res_re;
      got.im = out_ch.res_im;
      got.dz = out_ch.div_by_zero;
      got.sat = out_ch.saturated;
      sb.check_result(got);
    end
  end

  // Drive one beat, hold it until the unit takes it, and sometimes idle after it.
  task automatic send_operands(input operands_t op);
    in_ch.valid <= 1'b1;
    in_ch.mode <= op.mode;
    in_ch.left_re <= op.a;
    in_ch.left_im <= op.b;
    in_ch.right_re <= op.c;
    in_ch.right_im <= op.d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_operands(op);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000 + $urandom_range(0, 2);
      1: return 32'sh7FFF_FFFF - $urandom_range(0, 2);
      2: return $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
      3: return $signed(32'($urandom_range(0, 1 << 17))) - (1 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic operands_t make_op(input logic [2:0] m, input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic signed [31:0] c,
                                        input logic signed [31:0] d);
    operands_t op;
    op.mode = m; op.a = a; op.b = b; op.c = c; op.d = d;
    return op;
  endfunction

  initial begin
    operands_t op;
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_operands(make_op(cau_pkg::MODE_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1));
    send_operands(make_op(cau_pkg::MODE_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh8000_0000));
    send_operands(make_op(cau_pkg::MODE_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, -1));
    send_operands(make_op(cau_pkg::MODE_SUB, 5, -7, 3, 2));
    send_operands(make_op(cau_pkg::MODE_MUL, 32'sh0001_8000, 32'sh0000_8000, 32'sh0000_8000,
                          0));
    send_operands(make_op(cau_pkg::MODE_MUL, -32'sh0000_0001, 0, 32'sh0000_8000, 0));
    send_operands(make_op(cau_pkg::MODE_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000));
    send_operands(make_op(cau_pkg::MODE_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF));
    send_operands(make_op(cau_pkg::MODE_DIV, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000,
                          32'sh0001_0000));
    send_operands(make_op(cau_pkg::MODE_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0));
    send_operands(make_op(cau_pkg::MODE_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0));
    send_operands(make_op(cau_pkg::MODE_DIV, -32'sh0001_0000, 0, 32'sh0003_0000, 0));
    send_operands(make_op(cau_pkg::MODE_DIV, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000));
    send_operands(make_op(cau_pkg::MODE_MAG, 9, 9, 32'sh0003_0000, 32'sh0004_0000));
    send_operands(make_op(cau_pkg::MODE_MAG, 0, 0, 32'sh8000_0000, 32'sh8000_0000));
    send_operands(make_op(cau_pkg::MODE_MAG, 0, 0, 32'sh7FFF_FFFF, 0));
    send_operands(make_op(cau_pkg::MODE_MAG, 0, 0, 0, 0));
    send_operands(make_op(MODE_SPARE_LO, 1, 2, 3, 4));
    send_operands(make_op(MODE_SPARE_MID, 32'sh7FFF_FFFF, 1, 1, 1));
    send_operands(make_op(MODE_SPARE_HI, -1, -1, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i > N_RANDOM - 150);
      op.mode = ($urandom_range(0, 19) == 0) ?
                3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)) :
                3'($urandom_range(cau_pkg::MODE_ADD, cau_pkg::MODE_MAG));
      op.a = pick_value();
      op.b = pick_value();
      op.c = pick_value();
      op.d = pick_value();
      if (op.mode == cau_pkg::MODE_DIV && $urandom_range(0, 24) == 0) begin
        op.c = 0;
        op.d = 0;
      end
      send_operands(op);
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
